>>> sv/mw3d_pkg.sv
// shared types and codes for the 3d maze walker
package mw3d_pkg;

  // actions carried by an input item
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_PLACE = 2'd2;
  localparam logic [1:0] ACT_STEP  = 2'd3;

  // cell codes held in the grid
  localparam logic [3:0] CELL_OPEN    = 4'd0;
  localparam logic [3:0] CELL_WALL    = 4'd1;
  localparam logic [3:0] CELL_WALKER  = 4'd2;
  localparam logic [3:0] CELL_EXIT    = 4'd3;
  localparam logic [3:0] CELL_VISITED = 4'd4;
  localparam logic [3:0] CELL_FORK    = 4'd5;
  localparam logic [3:0] CELL_DEAD    = 4'd6;
  localparam logic [3:0] CELL_UP      = 4'd7;
  localparam logic [3:0] CELL_DOWN    = 4'd8;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MOVED      = 3'd1;
  localparam logic [2:0] ST_EXIT       = 3'd2;
  localparam logic [2:0] ST_STUCK      = 3'd3;
  localparam logic [2:0] ST_NO_OPENING = 3'd4;
  localparam logic [2:0] ST_NO_WALKER  = 3'd5;

  // neighbor directions in priority order
  localparam logic [2:0] DIR_NORTH = 3'd0;
  localparam logic [2:0] DIR_EAST  = 3'd1;
  localparam logic [2:0] DIR_SOUTH = 3'd2;
  localparam logic [2:0] DIR_WEST  = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;
  localparam int unsigned NUM_DIRS = 6;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_LAYERS = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic [3:0] cell_layer;
    logic [3:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] walker_row_out;
    logic [3:0] walker_col_out;
    logic [3:0] walker_layer_out;
    logic [3:0] read_value;
  } out_item_t;

endpackage

>>> sv/maze_walker_3d_dead_end_marking.sv
// top level of the 3d maze walker with dead-end marking
// The grid lives in one synchronous memory (one write and one read port,
// registered read data) and every action works on it one cell at a time,
// so the block takes one item at a time. A write and a read work on the
// addressed cell. A step reads the six neighbors, decides, then writes the
// cell being left and the new walker cell back to the memory (no writes
// when the exit is next to the walker or it is stuck, no reads with no
// walker). A place reads the cells of the grid in use in turn until it has
// found an open border cell for the walker and one for the exit, or runs
// out of cells. A result waiting on a stalled output holds the sequencer
// in its result state. The next item is taken while a result still waits
// on the output register.
module maze_walker_3d_dead_end_marking #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int MAX_LAYERS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mw3d_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mw3d_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mw3d_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int AW    = LW + RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [4:0] ROW_CAP = 5'((MAX_ROWS > 16) ? 16 : MAX_ROWS);
  localparam logic [4:0] COL_CAP = 5'((MAX_COLS > 16) ? 16 : MAX_COLS);
  localparam logic [4:0] LAY_CAP = 5'((MAX_LAYERS > 16) ? 16 : MAX_LAYERS);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXEC    = 9'b000000010,
    S_RDATA   = 9'b000000100,
    S_PSCAN   = 9'b000001000,
    S_SREAD   = 9'b000010000,
    S_SDECIDE = 9'b000100000,
    S_SWOLD   = 9'b001000000,
    S_SWNEW   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  typedef struct packed {
    logic       inb;
    logic [3:0] r;
    logic [3:0] c;
    logic [3:0] l;
  } nb_t;

  // clamp a dimension register to the range in use
  function automatic logic [4:0] eff_dim(logic [4:0] v, logic [4:0] cap);
    logic [4:0] res;
    res = (v == 5'd0) ? 5'd1 : v;
    if (res > cap) res = cap;
    return res;
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [3:0] r, logic [3:0] c,
                                              logic [3:0] l);
    return {LW'(l), RW'(r), CW'(c)};
  endfunction

  // neighbor of the walker in direction k, with its bounds test
  function automatic nb_t nb_coord(logic [2:0] k, logic [3:0] wr, logic [3:0] wc,
                                   logic [3:0] wl, logic [4:0] rows,
                                   logic [4:0] cols, logic [4:0] lays);
    logic [4:0] r5;
    logic [4:0] c5;
    logic [4:0] l5;
    logic       ok;
    nb_t        res;
    r5 = {1'b0, wr};
    c5 = {1'b0, wc};
    l5 = {1'b0, wl};
    ok = 1'b1;
    case (k)
      DIR_NORTH: r5 = r5 - 5'd1;
      DIR_EAST:  c5 = c5 + 5'd1;
      DIR_SOUTH: r5 = r5 + 5'd1;
      DIR_WEST:  c5 = c5 - 5'd1;
      DIR_UP:    l5 = l5 + 5'd1;
      DIR_DOWN:  l5 = l5 - 5'd1;
      default:   ok = 1'b0;
    endcase
    res.inb = ok && (r5 < rows) && (c5 < cols) && (l5 < lays);
    res.r   = r5[3:0];
    res.c   = c5[3:0];
    res.l   = l5[3:0];
    return res;
  endfunction

  function automatic logic in_grid(logic [3:0] r, logic [3:0] c, logic [3:0] l);
    return (32'(r) < MAX_ROWS) && (32'(c) < MAX_COLS) && (32'(l) < MAX_LAYERS);
  endfunction

  // grid memory
  logic [3:0]    cell_mem_q [DEPTH];
  logic [3:0]    rdata_q;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [3:0]    mem_wdata;

  // control and data registers
  state_e     state_q, state_d;
  in_item_t   item_q, item_d;
  logic [3:0] walker_r_q, walker_r_d, walker_c_q, walker_c_d, walker_l_q, walker_l_d;
  logic       walker_present_q, walker_present_d;
  logic [4:0] rows_q, cols_q, lays_q;
  logic [4:0] rows_eff, cols_eff, lays_eff;
  logic [2:0] status_q, status_d;
  logic [3:0] rval_q, rval_d;
  logic [3:0] ptr_r_q, ptr_r_d, ptr_c_q, ptr_c_d, ptr_l_q, ptr_l_d;
  logic       ptr_end_q, ptr_end_d;
  logic       phase_q, phase_d;
  logic       rd_pend_q, rd_pend_d;
  logic [3:0] rd_r_q, rd_r_d, rd_c_q, rd_c_d, rd_l_q, rd_l_d;
  logic [2:0] rd_k_q, rd_k_d;
  logic       rd_inb_q, rd_inb_d;
  logic [2:0] cnt_q, cnt_d;
  logic [NUM_DIRS-1:0]      usable_q, usable_d;
  logic [NUM_DIRS-1:0][3:0] val_q, val_d;
  logic [2:0] tgt_q, tgt_d;
  logic [3:0] mark_q, mark_d;
  out_item_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;

  // combinational helpers
  nb_t        nb_rd;
  nb_t        nb_tgt;
  logic       scan_border;
  logic       scan_found;
  logic       ptr_last_r, ptr_last_c, ptr_last_l;
  logic       exit_hit, open_hit, back_hit;
  logic [2:0] open_k, back_k;
  logic [2:0] usable_cnt;
  logic       cfg_wr;

  assign rows_eff = eff_dim(rows_q, ROW_CAP);
  assign cols_eff = eff_dim(cols_q, COL_CAP);
  assign lays_eff = eff_dim(lays_q, LAY_CAP);

  assign nb_rd  = nb_coord(cnt_q, walker_r_q, walker_c_q, walker_l_q,
                           rows_eff, cols_eff, lays_eff);
  assign nb_tgt = nb_coord(tgt_q, walker_r_q, walker_c_q, walker_l_q,
                           rows_eff, cols_eff, lays_eff);

  // place scan: border test of the cell whose data is back, and pointer wrap
  assign scan_border = (rd_c_q == 4'd0) || ({1'b0, rd_c_q} == cols_eff - 5'd1) ||
                       (rd_r_q == 4'd0) || ({1'b0, rd_r_q} == rows_eff - 5'd1);
  assign scan_found  = rd_pend_q && scan_border && (rdata_q == CELL_OPEN);
  assign ptr_last_r  = ({1'b0, ptr_r_q} == rows_eff - 5'd1);
  assign ptr_last_c  = ({1'b0, ptr_c_q} == cols_eff - 5'd1);
  assign ptr_last_l  = ({1'b0, ptr_l_q} == lays_eff - 5'd1);

  // step decision over the six collected neighbors, lowest direction wins
  always_comb begin
    exit_hit = 1'b0;
    open_hit = 1'b0;
    back_hit = 1'b0;
    open_k   = DIR_NORTH;
    back_k   = DIR_NORTH;
    for (int k = NUM_DIRS - 1; k >= 0; k--) begin
      if (usable_q[k] && val_q[k] == CELL_EXIT) begin
        exit_hit = 1'b1;
      end
      if (usable_q[k] && val_q[k] == CELL_OPEN) begin
        open_hit = 1'b1;
        open_k   = 3'(k);
      end
      if (usable_q[k] && (val_q[k] == CELL_VISITED || val_q[k] == CELL_FORK ||
                          val_q[k] == CELL_UP || val_q[k] == CELL_DOWN)) begin
        back_hit = 1'b1;
        back_k   = 3'(k);
      end
    end
  end

  assign usable_cnt = 3'($countones(usable_q));

  // sequencer
  always_comb begin
    state_d          = state_q;
    item_d           = item_q;
    walker_r_d       = walker_r_q;
    walker_c_d       = walker_c_q;
    walker_l_d       = walker_l_q;
    walker_present_d = walker_present_q;
    status_d         = status_q;
    rval_d           = rval_q;
    ptr_r_d          = ptr_r_q;
    ptr_c_d          = ptr_c_q;
    ptr_l_d          = ptr_l_q;
    ptr_end_d        = ptr_end_q;
    phase_d          = phase_q;
    rd_pend_d        = rd_pend_q;
    rd_r_d           = rd_r_q;
    rd_c_d           = rd_c_q;
    rd_l_d           = rd_l_q;
    rd_k_d           = rd_k_q;
    rd_inb_d         = rd_inb_q;
    cnt_d            = cnt_q;
    usable_d         = usable_q;
    val_d            = val_q;
    tgt_d            = tgt_q;
    mark_d           = mark_q;
    out_d            = out_q;
    out_valid_d      = out_valid_q;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_waddr        = cell_addr(walker_r_q, walker_c_q, walker_l_q);
    mem_raddr        = cell_addr(item_q.cell_row, item_q.cell_col, item_q.cell_layer);
    mem_wdata        = mark_q;

    // output register drains independently of the sequencer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        status_d = ST_OK;
        rval_d   = CELL_OPEN;
        case (item_q.action)
          ACT_WRITE: begin
            mem_waddr = cell_addr(item_q.cell_row, item_q.cell_col, item_q.cell_layer);
            mem_wdata = item_q.cell_value;
            mem_we    = (item_q.cell_value <= CELL_DOWN) &&
                        in_grid(item_q.cell_row, item_q.cell_col, item_q.cell_layer);
            state_d   = S_DONE;
          end
          ACT_READ: begin
            if (in_grid(item_q.cell_row, item_q.cell_col, item_q.cell_layer)) begin
              mem_re  = 1'b1;
              state_d = S_RDATA;
            end else begin
              state_d = S_DONE;
            end
          end
          ACT_PLACE: begin
            ptr_r_d   = 4'd0;
            ptr_c_d   = 4'd0;
            ptr_l_d   = 4'd0;
            ptr_end_d = 1'b0;
            phase_d   = 1'b0;
            rd_pend_d = 1'b0;
            state_d   = S_PSCAN;
          end
          default: begin
            if (walker_present_q) begin
              cnt_d     = DIR_NORTH;
              rd_pend_d = 1'b0;
              usable_d  = '0;
              state_d   = S_SREAD;
            end else begin
              status_d = ST_NO_WALKER;
              state_d  = S_DONE;
            end
          end
        endcase
      end

      S_RDATA: begin
        rval_d  = rdata_q;
        state_d = S_DONE;
      end

      // one border candidate per cycle, walker first and then exit
      S_PSCAN: begin
        mem_waddr = cell_addr(rd_r_q, rd_c_q, rd_l_q);
        mem_wdata = phase_q ? CELL_EXIT : CELL_WALKER;
        mem_raddr = cell_addr(ptr_r_q, ptr_c_q, ptr_l_q);
        if (scan_found) begin
          mem_we    = 1'b1;
          rd_pend_d = 1'b0;
          if (!phase_q) begin
            walker_r_d       = rd_r_q;
            walker_c_d       = rd_c_q;
            walker_l_d       = rd_l_q;
            walker_present_d = 1'b1;
            phase_d          = 1'b1;
          end else begin
            status_d = ST_OK;
            state_d  = S_DONE;
          end
        end else if (ptr_end_q) begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            status_d = ST_NO_OPENING;
            state_d  = S_DONE;
          end
        end else begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_r_d    = ptr_r_q;
          rd_c_d    = ptr_c_q;
          rd_l_d    = ptr_l_q;
          if (!ptr_last_r) begin
            ptr_r_d = ptr_r_q + 4'd1;
          end else begin
            ptr_r_d = 4'd0;
            if (!ptr_last_c) begin
              ptr_c_d = ptr_c_q + 4'd1;
            end else begin
              ptr_c_d = 4'd0;
              if (!ptr_last_l) begin
                ptr_l_d = ptr_l_q + 4'd1;
              end else begin
                ptr_l_d   = 4'd0;
                ptr_end_d = 1'b1;
              end
            end
          end
        end
      end

      // issue six neighbor reads, collect each in the cycle after it is issued
      S_SREAD: begin
        mem_raddr = cell_addr(nb_rd.r, nb_rd.c, nb_rd.l);
        if (rd_pend_q) begin
          usable_d[rd_k_q] = rd_inb_q && (rdata_q != CELL_WALL) && (rdata_q != CELL_DEAD);
          val_d[rd_k_q]    = rdata_q;
        end
        if (cnt_q < 3'(NUM_DIRS)) begin
          mem_re    = nb_rd.inb;
          rd_pend_d = 1'b1;
          rd_k_d    = cnt_q;
          rd_inb_d  = nb_rd.inb;
          cnt_d     = cnt_q + 3'd1;
        end else begin
          rd_pend_d = 1'b0;
          state_d   = S_SDECIDE;
        end
      end

      S_SDECIDE: begin
        if (exit_hit) begin
          status_d = ST_EXIT;
          state_d  = S_DONE;
        end else if (open_hit) begin
          tgt_d = open_k;
          if (usable_cnt > 3'd2) begin
            mark_d = CELL_FORK;
          end else if (open_k == DIR_UP) begin
            mark_d = CELL_UP;
          end else if (open_k == DIR_DOWN) begin
            mark_d = CELL_DOWN;
          end else begin
            mark_d = CELL_VISITED;
          end
          state_d = S_SWOLD;
        end else if (back_hit) begin
          tgt_d   = back_k;
          mark_d  = CELL_DEAD;
          state_d = S_SWOLD;
        end else begin
          status_d = ST_STUCK;
          state_d  = S_DONE;
        end
      end

      // mark the cell being left
      S_SWOLD: begin
        mem_we  = 1'b1;
        state_d = S_SWNEW;
      end

      // walker enters its new cell
      S_SWNEW: begin
        mem_waddr  = cell_addr(nb_tgt.r, nb_tgt.c, nb_tgt.l);
        mem_wdata  = CELL_WALKER;
        mem_we     = 1'b1;
        walker_r_d = nb_tgt.r;
        walker_c_d = nb_tgt.c;
        walker_l_d = nb_tgt.l;
        status_d   = ST_MOVED;
        state_d    = S_DONE;
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d = '{status:           status_q,
                    walker_row_out:   walker_r_q,
                    walker_col_out:   walker_c_q,
                    walker_layer_out: walker_l_q,
                    read_value:       rval_q};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // grid memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= cell_mem_q[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      walker_r_q       <= 4'd0;
      walker_c_q       <= 4'd0;
      walker_l_q       <= 4'd0;
      walker_present_q <= 1'b0;
      rd_pend_q        <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      walker_r_q       <= walker_r_d;
      walker_c_q       <= walker_c_d;
      walker_l_q       <= walker_l_d;
      walker_present_q <= walker_present_d;
      rd_pend_q        <= rd_pend_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // working data
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    status_q  <= status_d;
    rval_q    <= rval_d;
    ptr_r_q   <= ptr_r_d;
    ptr_c_q   <= ptr_c_d;
    ptr_l_q   <= ptr_l_d;
    ptr_end_q <= ptr_end_d;
    phase_q   <= phase_d;
    rd_r_q    <= rd_r_d;
    rd_c_q    <= rd_c_d;
    rd_l_q    <= rd_l_d;
    rd_k_q    <= rd_k_d;
    rd_inb_q  <= rd_inb_d;
    cnt_q     <= cnt_d;
    usable_q  <= usable_d;
    val_q     <= val_d;
    tgt_q     <= tgt_d;
    mark_q    <= mark_d;
    out_q     <= out_d;
  end

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 5'd16;
      cols_q <= 5'd16;
      lays_q <= 5'd16;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROWS:   rows_q <= pwdata[4:0];
        REG_COLS:   cols_q <= pwdata[4:0];
        REG_LAYERS: lays_q <= pwdata[4:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:   prdata = {27'd0, rows_q};
      REG_COLS:   prdata = {27'd0, cols_q};
      REG_LAYERS: prdata = {27'd0, lays_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign pready      = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a new result only ever comes from the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside the result state");

  // the walker only appears through a place scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(walker_present_q) |-> $past(state_q == S_PSCAN))
    else $error("walker placed outside a place scan");

  // all six neighbor reads are collected before the decision
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SDECIDE) |-> ($past(state_q == S_SREAD) && !rd_pend_q))
    else $error("step decision with a neighbor read still pending");

  // a move always ends with a placed walker and a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWNEW) |=> (walker_present_q && state_q == S_DONE))
    else $error("move did not complete");

endmodule

>>> verif/maze_walker_3d_dead_end_marking_tb.sv
// self-checking testbench for the 3d maze walker with dead-end marking
`timescale 1ns / 100ps

module maze_walker_3d_dead_end_marking_tb;
  import mw3d_pkg::*;

  localparam int GRID_CELLS  = 4096;
  localparam int ITEM_BUDGET = 1750;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // block ports
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  maze_walker_3d_dead_end_marking i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // predicted grid, walker and extent registers
  logic [3:0] maze_cells [GRID_CELLS];
  bit         cell_written [GRID_CELLS];
  logic [3:0] walker_r = '0;
  logic [3:0] walker_c = '0;
  logic [3:0] walker_l = '0;
  bit         walker_placed = 1'b0;
  logic [4:0] rows_reg = 5'd16;
  logic [4:0] cols_reg = 5'd16;
  logic [4:0] lays_reg = 5'd16;
  logic [2:0] last_walk_status = ST_OK;

  // item traffic
  in_item_t  queued_actions [$];
  out_item_t predicted_outcomes [$];
  int actions_queued   = 0;
  int actions_offered  = 0;
  int actions_taken    = 0;
  int outcomes_checked = 0;
  int items_issued     = 0;
  int mismatch_count   = 0;
  int send_gap_pct     = 0;
  int stall_pct        = 0;

  // tallies for the summary
  int moves_seen      = 0;
  int exits_seen      = 0;
  int stuck_seen      = 0;
  int failed_places   = 0;

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch on %s at %0t ns: got %0d, want %0d", what, $time, got, want);
    mismatch_count++;
  endtask

  // register value in use, saturated to 1..16
  function automatic int extent(logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > 5'd16) return 16;
    return int'(v);
  endfunction

  function automatic int grid_addr(int r, int c, int l);
    return (l * 16 + r) * 16 + c;
  endfunction

  // scan layer, column, row for the first open border cell and claim it
  function automatic bit claim_border_cell(logic [3:0] code, output int pr, output int pc,
                                           output int pl);
    int rows, cols, lays;
    rows = extent(rows_reg);
    cols = extent(cols_reg);
    lays = extent(lays_reg);
    pr = 0;
    pc = 0;
    pl = 0;
    for (int l = 0; l < lays; l++)
      for (int c = 0; c < cols; c++)
        for (int r = 0; r < rows; r++)
          if (maze_cells[grid_addr(r, c, l)] == CELL_OPEN &&
              (c == 0 || c == cols - 1 || r == 0 || r == rows - 1)) begin
            maze_cells[grid_addr(r, c, l)] = code;
            pr = r;
            pc = c;
            pl = l;
            return 1'b1;
          end
    return 1'b0;
  endfunction

  // one move of the walk: exit check, forward move, backtrack, or stuck
  function automatic logic [2:0] walk_once();
    int rows, cols, lays, usable_cnt, pick;
    int nr [NUM_DIRS];
    int nc [NUM_DIRS];
    int nl [NUM_DIRS];
    bit usable [NUM_DIRS];
    logic [3:0] seen [NUM_DIRS];
    logic [3:0] leave_mark;
    rows = extent(rows_reg);
    cols = extent(cols_reg);
    lays = extent(lays_reg);
    usable_cnt = 0;
    pick = -1;
    leave_mark = CELL_DEAD;
    for (int k = 0; k < NUM_DIRS; k++) begin
      nr[k] = int'(walker_r);
      nc[k] = int'(walker_c);
      nl[k] = int'(walker_l);
      case (3'(k))
        DIR_NORTH: nr[k] = nr[k] - 1;
        DIR_EAST:  nc[k] = nc[k] + 1;
        DIR_SOUTH: nr[k] = nr[k] + 1;
        DIR_WEST:  nc[k] = nc[k] - 1;
        DIR_UP:    nl[k] = nl[k] + 1;
        default:   nl[k] = nl[k] - 1;
      endcase
      usable[k] = 1'b0;
      seen[k] = CELL_OPEN;
      if (nr[k] >= 0 && nr[k] < rows && nc[k] >= 0 && nc[k] < cols &&
          nl[k] >= 0 && nl[k] < lays) begin
        seen[k] = maze_cells[grid_addr(nr[k], nc[k], nl[k])];
        if (seen[k] != CELL_WALL && seen[k] != CELL_DEAD) begin
          usable[k] = 1'b1;
          usable_cnt++;
        end
      end
    end
    for (int k = 0; k < NUM_DIRS; k++)
      if (usable[k] && seen[k] == CELL_EXIT) return ST_EXIT;
    // forward onto an open cell
    for (int k = 0; k < NUM_DIRS && pick < 0; k++)
      if (usable[k] && seen[k] == CELL_OPEN) begin
        pick = k;
        if (usable_cnt > 2) leave_mark = CELL_FORK;
        else if (3'(k) == DIR_UP) leave_mark = CELL_UP;
        else if (3'(k) == DIR_DOWN) leave_mark = CELL_DOWN;
        else leave_mark = CELL_VISITED;
      end
    // backtrack onto a marked cell
    for (int k = 0; k < NUM_DIRS && pick < 0; k++)
      if (usable[k] && (seen[k] == CELL_VISITED || seen[k] == CELL_FORK ||
                        seen[k] == CELL_UP || seen[k] == CELL_DOWN)) begin
        pick = k;
        leave_mark = CELL_DEAD;
      end
    if (pick < 0) return ST_STUCK;
    maze_cells[grid_addr(int'(walker_r), int'(walker_c), int'(walker_l))] = leave_mark;
    maze_cells[grid_addr(nr[pick], nc[pick], nl[pick])] = CELL_WALKER;
    walker_r = 4'(nr[pick]);
    walker_c = 4'(nc[pick]);
    walker_l = 4'(nl[pick]);
    return ST_MOVED;
  endfunction

  // expected result of one accepted item, updating the predicted state
  function automatic out_item_t predict_outcome(in_item_t it);
    out_item_t res;
    int pr, pc, pl, a;
    res = '0;
    a = grid_addr(int'(it.cell_row), int'(it.cell_col), int'(it.cell_layer));
    case (it.action)
      ACT_WRITE: begin
        if (it.cell_value <= CELL_DOWN) begin
          maze_cells[a] = it.cell_value;
          cell_written[a] = 1'b1;
        end
      end
      ACT_READ: res.read_value = maze_cells[a];
      ACT_PLACE: begin
        if (!claim_border_cell(CELL_WALKER, pr, pc, pl)) begin
          res.status = ST_NO_OPENING;
        end else begin
          walker_r = 4'(pr);
          walker_c = 4'(pc);
          walker_l = 4'(pl);
          walker_placed = 1'b1;
          if (!claim_border_cell(CELL_EXIT, pr, pc, pl)) res.status = ST_NO_OPENING;
        end
        if (res.status == ST_NO_OPENING) failed_places++;
      end
      default: begin
        res.status = walker_placed ? walk_once() : ST_NO_WALKER;
        last_walk_status = res.status;
        if (res.status == ST_MOVED) moves_seen++;
        if (res.status == ST_EXIT) exits_seen++;
        if (res.status == ST_STUCK) stuck_seen++;
      end
    endcase
    res.walker_row_out   = walker_r;
    res.walker_col_out   = walker_c;
    res.walker_layer_out = walker_l;
    return res;
  endfunction

  // driver: next item and receiver stall at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      if (actions_taken == actions_offered) begin
        if (queued_actions.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= queued_actions.pop_front();
          actions_offered++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: check results, then predict for the item taken at this edge
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_outcomes.size() == 0) begin
          flag_mismatch("result with nothing expected", int'(out_data_o), 0);
        end else begin
          want = predicted_outcomes.pop_front();
          if (out_data_o.status !== want.status)
            flag_mismatch("status", int'(out_data_o.status), int'(want.status));
          if (out_data_o.walker_row_out !== want.walker_row_out)
            flag_mismatch("walker row", int'(out_data_o.walker_row_out),
                          int'(want.walker_row_out));
          if (out_data_o.walker_col_out !== want.walker_col_out)
            flag_mismatch("walker column", int'(out_data_o.walker_col_out),
                          int'(want.walker_col_out));
          if (out_data_o.walker_layer_out !== want.walker_layer_out)
            flag_mismatch("walker layer", int'(out_data_o.walker_layer_out),
                          int'(want.walker_layer_out));
          if (out_data_o.read_value !== want.read_value)
            flag_mismatch("read value", int'(out_data_o.read_value),
                          int'(want.read_value));
          outcomes_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predicted_outcomes.insert(predicted_outcomes.size(), predict_outcome(in_data_i));
        actions_taken++;
      end
    end
  end

  // register write, then read back
  task automatic program_extent(logic [1:0] idx, logic [4:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {27'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_ROWS: rows_reg = val;
      REG_COLS: cols_reg = val;
      default:  lays_reg = val;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[4:0] !== val)
      flag_mismatch("register readback", int'(prdata[4:0]), int'(val));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_extents(logic [4:0] rows, logic [4:0] cols, logic [4:0] lays);
    program_extent(REG_ROWS, rows);
    program_extent(REG_COLS, cols);
    program_extent(REG_LAYERS, lays);
  endtask

  task automatic queue_action(logic [1:0] act, int r, int c, int l, int v);
    in_item_t it;
    it.action     = act;
    it.cell_row   = 4'(r);
    it.cell_col   = 4'(c);
    it.cell_layer = 4'(l);
    it.cell_value = 4'(v);
    queued_actions.insert(queued_actions.size(), it);
    actions_queued++;
    items_issued++;
  endtask

  // place or step with don't-care coordinate and value fields
  task automatic queue_junk(logic [1:0] act);
    queue_action(act, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                 $urandom_range(15));
  endtask

  task automatic settle_actions();
    wait (actions_taken == actions_queued);
  endtask

  task automatic settle_all();
    wait (actions_taken == actions_queued && outcomes_checked == actions_taken);
  endtask

  task automatic take_step(output logic [2:0] st);
    queue_junk(ACT_STEP);
    settle_actions();
    st = last_walk_status;
  endtask

  function automatic bit region_ready();
    for (int l = 0; l < extent(lays_reg); l++)
      for (int c = 0; c < extent(cols_reg); c++)
        for (int r = 0; r < extent(rows_reg); r++)
          if (!cell_written[grid_addr(r, c, l)]) return 1'b0;
    return 1'b1;
  endfunction

  // fill the region in use with a random maze, optionally walled on every row and column border
  task automatic build_maze(bit sealed);
    int rows, cols, lays, pick, code;
    rows = extent(rows_reg);
    cols = extent(cols_reg);
    lays = extent(lays_reg);
    for (int l = 0; l < lays; l++)
      for (int c = 0; c < cols; c++)
        for (int r = 0; r < rows; r++) begin
          pick = $urandom_range(99);
          if (pick < 58) code = CELL_OPEN;
          else if (pick < 88) code = CELL_WALL;
          else code = $urandom_range(int'(CELL_WALKER), int'(CELL_DOWN));
          if (sealed && (c == 0 || c == cols - 1 || r == 0 || r == rows - 1))
            code = CELL_WALL;
          queue_action(ACT_WRITE, r, c, l, code);
        end
  endtask

  // reads, stray writes, ignored writes and a fresh place
  task automatic stir_noise();
    int r, c, l, pick;
    r = $urandom_range(15);
    c = $urandom_range(15);
    l = $urandom_range(15);
    pick = $urandom_range(9);
    if (pick < 4) begin
      if (!cell_written[grid_addr(r, c, l)]) begin
        r = $urandom_range(extent(rows_reg) - 1);
        c = $urandom_range(extent(cols_reg) - 1);
        l = $urandom_range(extent(lays_reg) - 1);
      end
      queue_action(ACT_READ, r, c, l, $urandom_range(15));
    end else if (pick < 6) begin
      queue_action(ACT_WRITE, r, c, l, $urandom_range(int'(CELL_DOWN) + 1, 15));
    end else if (pick < 9) begin
      queue_action(ACT_WRITE, r, c, l, $urandom_range(int'(CELL_DOWN)));
    end else begin
      queue_junk(ACT_PLACE);
    end
  endtask

  // one maze: build, place, walk until the exit or stuck, then drain
  task automatic run_maze();
    logic [2:0] st;
    int cap;
    build_maze($urandom_range(7) == 0);
    repeat ($urandom_range(2)) stir_noise();
    queue_junk(ACT_PLACE);
    cap = 2 * extent(rows_reg) * extent(cols_reg) * extent(lays_reg) + 8;
    for (int n = 0; n < cap; n++) begin
      if ($urandom_range(7) == 0) stir_noise();
      take_step(st);
      if (st == ST_EXIT || st == ST_STUCK) begin
        if ($urandom_range(3) == 0) take_step(st);
        break;
      end
    end
    settle_all();
  endtask

  // watchdog
  initial begin
    #20000000;
    $display("watchdog expired before the run finished");
    $display("Mismatches found");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [2:0] st;
    int phase, mazes;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: small 3x3 single-layer grid
    apply_extents(5'd3, 5'd3, 5'd1);
    queue_junk(ACT_STEP);
    queue_action(ACT_WRITE, 15, 15, 15, int'(CELL_DOWN));
    queue_action(ACT_READ, 15, 15, 15, 0);
    queue_action(ACT_WRITE, 15, 15, 15, 15);
    queue_action(ACT_READ, 15, 15, 15, 0);
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) queue_action(ACT_WRITE, r, c, 0, int'(CELL_WALL));
    // no open border cell at all, then room for the walker but not the exit
    queue_junk(ACT_PLACE);
    queue_junk(ACT_STEP);
    queue_action(ACT_WRITE, 0, 1, 0, int'(CELL_OPEN));
    queue_junk(ACT_PLACE);
    queue_junk(ACT_STEP);
    // open a corridor south to a hand-placed exit
    queue_action(ACT_WRITE, 1, 1, 0, int'(CELL_OPEN));
    queue_action(ACT_WRITE, 2, 1, 0, int'(CELL_EXIT));
    queue_junk(ACT_STEP);
    queue_junk(ACT_STEP);

    // random phases; idling style rotates with each grid shape
    phase = 0;
    while (items_issued < ITEM_BUDGET) begin
      settle_all();
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 49; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 49; end
        default: begin send_gap_pct = 25; stall_pct = 25; end
      endcase
      case (phase)
        0: apply_extents(5'd16, 5'd16, 5'd0);
        1: apply_extents(5'd0, 5'd2, 5'd31);
        2: apply_extents(5'd31, 5'd1, 5'd2);
        3: apply_extents(5'd1, 5'd0, 5'd16);
        default: apply_extents(5'($urandom_range(5)), 5'($urandom_range(5)),
                               5'($urandom_range(4)));
      endcase
      // the walker may now sit outside the new extents
      if (walker_placed && region_ready()) repeat (2) take_step(st);
      mazes = (phase == 0) ? 1 : $urandom_range(1, 3);
      repeat (mazes) run_maze();
      phase++;
    end

    settle_all();
    repeat (40) @(posedge clk_i);
    $display("covered %0d items over %0d grid shapes, %0d results checked",
             items_issued, phase + 1, outcomes_checked);
    $display("walker moved %0d times, reached an exit %0d times, got stuck %0d times",
             moves_seen, exits_seen, stuck_seen);
    $display("%0d places ran short of border openings", failed_places);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/mw3d_pkg.sv
sv/maze_walker_3d_dead_end_marking.sv
verif/maze_walker_3d_dead_end_marking_tb.sv
